### design/plas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PARCOR lattice filter.
// No dependencies; imported by plas_qmul, plas_bstore and the top level.
package plas_pkg;

	localparam int DATA_W     = 32;
	localparam int ACC_W      = 64;
	localparam int ORDER_W    = 6;
	localparam int CIDX_W     = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int IN_TDATA_W = 72;
	localparam int IN_TUSER_W = 2;
	localparam int Q_SHIFT    = 31;

	localparam logic [ACC_W-1:0] ROUND_HALF = 64'h0000_0000_4000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 1'd1;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	localparam logic MODE_ANALYSIS  = 1'b0;
	localparam logic MODE_SYNTHESIS = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] k;
		logic [ACC_W-1:0]  v;
	} qmul_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] prod;
	} qmul_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL1,
		ST_WAIT1,
		ST_WAIT2,
		ST_FLUSH,
		ST_FIN
	} plas_state_t;

endpackage

### design/plas_qmul.sv
`timescale 1ns / 1ps
// Shared rounded Q31 multiplier: (k * v + 2^30) >>> 31 modulo 2^64.
// One 33x33 multiplier used twice per product. Depends on plas_pkg.
module plas_qmul (
	input  logic              clk,
	input  logic              arst_n,
	input  plas_pkg::qmul_req_t req,
	output plas_pkg::qmul_rsp_t rsp
);
	import plas_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LO   = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	logic [1:0]                 ph_q;
	logic                       done_q;
	logic [DATA_W-1:0]          k_q;
	logic [ACC_W-1:0]           v_q;
	logic [ACC_W-1:0]           acc_q;
	logic [DATA_W-1:0]          hi_q;
	logic [ACC_W-1:0]           prod_q;
	logic signed [DATA_W:0]     mul_a;
	logic signed [DATA_W:0]     mul_b;
	logic signed [2*DATA_W+1:0] mul_p;
	logic [ACC_W-1:0]           sum;

	// low half of v is unsigned, high half carries the sign
	assign mul_a = $signed({k_q[DATA_W-1], k_q});
	assign mul_b = (ph_q == PH_LO) ? $signed({1'b0, v_q[DATA_W-1:0]})
	                               : $signed({v_q[ACC_W-1], v_q[ACC_W-1:DATA_W]});
	assign mul_p = mul_a * mul_b;
	assign sum   = acc_q + {hi_q, {DATA_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: if (req.start) ph_q <= PH_LO;
				PH_LO:   ph_q <= PH_HI;
				PH_HI:   ph_q <= PH_SUM;
				default: begin
					ph_q   <= PH_IDLE;
					done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && req.start) begin
			k_q <= req.k;
			v_q <= req.v;
		end
		if (ph_q == PH_LO)
			acc_q <= mul_p[ACC_W-1:0];
		if (ph_q == PH_HI) begin
			hi_q  <= mul_p[DATA_W-1:0];
			acc_q <= acc_q + ROUND_HALF;
		end
		if (ph_q == PH_SUM)
			prod_q <= {{Q_SHIFT{sum[ACC_W-1]}}, sum[ACC_W-1:Q_SHIFT]};
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (ph_q == PH_IDLE || done_q))
		else $error("qmul started while busy");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && ph_q == PH_IDLE) |=> ##3 rsp.done)
		else $error("qmul result not ready after four cycles");
`endif

endmodule

### design/plas_bstore.sv
`timescale 1ns / 1ps
// Backward residual store: one write and one registered read per cycle,
// with a valid bit per entry so a block start clears it at once. Uses plas_pkg.
module plas_bstore #(
	parameter int DEPTH  = 33,
	parameter int ADDR_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [plas_pkg::ACC_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [plas_pkg::ACC_W-1:0]  wr_data
);
	import plas_pkg::*;

	logic [ACC_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [ACC_W-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clear)
				vld_q <= '0;
			else if (wr_en)
				vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// an entry not written since the last clear reads as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### design/parcor_lattice_analysis_synthesis_top.sv
`timescale 1ns / 1ps
// PARCOR lattice filter, top level: sequencer, coefficient memory, I/O.
// Depends on plas_pkg, plas_qmul and plas_bstore.
//
// Input stream s_*: each word either loads one Q31 reflection coefficient
// (tuser func = load) or pushes one sample through the lattice. A load gives
// no output word. A sample in analysis mode yields the top-stage forward
// residual; in synthesis mode it is taken as a residual and the
// reconstructed sample comes out. tuser block_start clears all backward
// residuals before the sample is used.
// Output stream m_*: one word per sample, clipped to int32, tuser flags a clip.
// Configuration: cfg_index 0 writes filter_order, 1 writes mode; write only
// while no sample is in flight. cfg_ready is always high.
// Sequence: for each stage, up to the order in use (capped at MAX_STAGES),
// the stores are read, then two rounded products are formed on the single
// shared multiplier (two 33x33 multiplies, a summing step and a result
// register each). At order zero no stage runs. s_tready stays low from
// acceptance of a sample until it returns; the result word shows up as
// s_tready rises. A finished word sits in the output register; the next
// item is accepted meanwhile, but a second result waits until m_tready
// takes the first. Reset clears the residuals, the control and config
// registers and the output valid; coefficients hold nothing until loaded.
module parcor_lattice_analysis_synthesis_top #(
	parameter int MAX_STAGES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] sample_in, [37:32] coef_index, [69:38] coef_value, [71:70] zero
	input  logic [plas_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [0] func, [1] block_start
	input  logic [plas_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] result_sample
	output logic [plas_pkg::DATA_W-1:0]       m_tdata,
	// [0] saturated
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [plas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [plas_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import plas_pkg::*;

	localparam int SW     = $clog2(MAX_STAGES + 1);
	localparam int CW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int BDEPTH = MAX_STAGES + 1;

	plas_state_t state_q, state_d;

	logic [ORDER_W-1:0] filter_order_q;
	logic               mode_q;
	logic [SW-1:0]      s_q;
	logic [SW-1:0]      order_cap;
	logic               pend_vld_q;
	logic [SW-1:0]      pend_addr_q;
	logic [ACC_W-1:0]   pend_data_q;
	logic [ACC_W-1:0]   x_q;
	logic [ACC_W-1:0]   fwd_q;
	logic [DATA_W-1:0]  k_q;
	logic [ACC_W-1:0]   bv_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_sat_q;

	logic               in_func;
	logic               in_block_start;
	logic [DATA_W-1:0]  in_sample;
	logic [CIDX_W-1:0]  in_coef_index;
	logic [DATA_W-1:0]  in_coef_value;
	logic [ACC_W-1:0]   in_sample_ext;
	logic               s_accept;
	logic               coef_wr;

	logic [DATA_W-1:0]  coef_mem [MAX_STAGES];
	logic [DATA_W-1:0]  coef_rd_q;
	logic [CW-1:0]      coef_rd_addr;

	logic               b_clear;
	logic [SW-1:0]      b_rd_addr;
	logic [ACC_W-1:0]   b_rd_data;
	logic               b_wr_en;
	logic [SW-1:0]      b_wr_addr;
	logic [ACC_W-1:0]   b_wr_data;

	qmul_req_t          qreq;
	qmul_rsp_t          qrsp;

	logic               last_stage;
	logic               fin_load;
	logic               clip;
	logic [DATA_W-1:0]  clip_val;

	assign in_func        = s_tuser[0];
	assign in_block_start = s_tuser[1];
	assign in_sample      = s_tdata[31:0];
	assign in_coef_index  = s_tdata[37:32];
	assign in_coef_value  = s_tdata[69:38];
	assign in_sample_ext  = {{(ACC_W-DATA_W){in_sample[DATA_W-1]}}, in_sample};
	assign s_accept       = s_tvalid && s_tready;
	assign cfg_ready      = 1'b1;

	always_comb begin
		if (int'(filter_order_q) > MAX_STAGES)
			order_cap = SW'(MAX_STAGES);
		else
			order_cap = SW'(filter_order_q);
	end

	assign last_stage = (mode_q == MODE_ANALYSIS) ? (s_q == order_cap) : (s_q == SW'(1));

	// coefficient memory, written by load words
	assign coef_wr = s_accept && in_func == FUNC_LOAD &&
	                 int'(in_coef_index) >= 1 && int'(in_coef_index) <= MAX_STAGES;
	assign coef_rd_addr = CW'(s_q - SW'(1));

	always_ff @(posedge clk) begin
		coef_rd_q <= coef_mem[coef_rd_addr];
		if (coef_wr)
			coef_mem[CW'(in_coef_index - CIDX_W'(1))] <= in_coef_value;
	end

	plas_bstore #(
		.DEPTH  (BDEPTH),
		.ADDR_W (SW)
	) u_bstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (b_clear),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data),
		.wr_en   (b_wr_en),
		.wr_addr (b_wr_addr),
		.wr_data (b_wr_data)
	);

	plas_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.rsp    (qrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		b_clear    = 1'b0;
		b_rd_addr  = s_q - SW'(1);
		b_wr_en    = 1'b0;
		b_wr_addr  = pend_addr_q;
		b_wr_data  = pend_data_q;
		qreq.start = 1'b0;
		qreq.k     = coef_rd_q;
		qreq.v     = b_rd_data;
		fin_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_accept && in_func == FUNC_SAMPLE) begin
					b_clear = in_block_start;
					state_d = (order_cap == '0) ? ST_FIN : ST_READ;
				end
			end
			ST_READ: state_d = ST_MUL1;
			ST_MUL1: begin
				// first product k*b[s-1]; retire the previous stage's residual
				qreq.start = 1'b1;
				b_wr_en    = pend_vld_q;
				state_d    = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (qrsp.done) begin
					qreq.start = 1'b1;
					qreq.k     = k_q;
					qreq.v     = (mode_q == MODE_SYNTHESIS) ? fwd_q + qrsp.prod : fwd_q;
					state_d    = ST_WAIT2;
				end
			end
			ST_WAIT2: begin
				if (qrsp.done)
					state_d = last_stage ? ST_FLUSH : ST_READ;
			end
			ST_FLUSH: begin
				b_wr_en = pend_vld_q;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					b_wr_en   = 1'b1;
					b_wr_addr = '0;
					b_wr_data = (mode_q == MODE_ANALYSIS) ? x_q : fwd_q;
					fin_load  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign clip = !((&fwd_q[ACC_W-1:DATA_W-1]) || !(|fwd_q[ACC_W-1:DATA_W-1]));
	assign clip_val = fwd_q[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_order_q <= '0;
			mode_q         <= MODE_ANALYSIS;
			s_q            <= '0;
			pend_vld_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FILTER_ORDER: filter_order_q <= cfg_data[ORDER_W-1:0];
					REG_MODE:         mode_q         <= cfg_data[0];
					default:          ;
				endcase
			end
			if (state_q == ST_IDLE && s_accept && in_func == FUNC_SAMPLE) begin
				s_q        <= (mode_q == MODE_ANALYSIS) ? SW'(1) : order_cap;
				pend_vld_q <= 1'b0;
			end
			if (state_q == ST_MUL1 || state_q == ST_FLUSH)
				pend_vld_q <= 1'b0;
			if (state_q == ST_WAIT2 && qrsp.done) begin
				pend_vld_q <= 1'b1;
				if (!last_stage)
					s_q <= (mode_q == MODE_ANALYSIS) ? s_q + SW'(1) : s_q - SW'(1);
			end
			// hold the word until taken; a new one may replace it at the same edge
			out_valid_q <= fin_load || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_accept && in_func == FUNC_SAMPLE) begin
			x_q   <= in_sample_ext;
			fwd_q <= in_sample_ext;
		end
		if (state_q == ST_MUL1) begin
			k_q  <= coef_rd_q;
			bv_q <= b_rd_data;
		end
		if (state_q == ST_WAIT1 && qrsp.done)
			fwd_q <= (mode_q == MODE_SYNTHESIS) ? fwd_q + qrsp.prod : fwd_q - qrsp.prod;
		if (state_q == ST_WAIT2 && qrsp.done) begin
			pend_data_q <= bv_q - qrsp.prod;
			pend_addr_q <= s_q;
		end
		if (fin_load) begin
			out_data_q <= clip ? clip_val : fwd_q[DATA_W-1:0];
			out_sat_q  <= clip;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

`ifndef SYNTHESIS
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		qrsp.done |-> (state_q == ST_WAIT1 || state_q == ST_WAIT2))
		else $error("multiplier result arrived outside a wait state");
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (s_q != '0 && s_q <= order_cap))
		else $error("stage counter out of range");
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_func == FUNC_SAMPLE) |=> !s_tready)
		else $error("input ready while a sample is in flight");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> m_tvalid)
		else $error("finished result not presented");
`endif

endmodule
